// ===== rtl/ttdds_pkg.sv =====
package ttdds_pkg;

  // Field and datapath widths that the request and result formats fix.
  localparam int AMP_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam int TUNE_W   = 32;
  localparam int SINE_W   = 15;
  localparam int WEIGHT_W = 15;
  localparam int MIX_W    = 32;
  // Q30 mix times Q1.15 gain is Q45; two more bits hold the sign and the rounding carry.
  localparam int PROD_W   = 48;
  localparam int DIGIT_W  = 4;
  localparam int NCH      = 3;

  localparam int AMP_DIGITS = AMP_W / DIGIT_W;
  localparam int LOOK_LEN   = NCH + 1;
  localparam int CNT_W      = $clog2((LOOK_LEN > AMP_DIGITS) ? LOOK_LEN : AMP_DIGITS);

  localparam int PHASE_BITS_DEF     = 32;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF    = 16;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Register map.
  localparam int CFG_ADDR_W = 4;
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_ENABLE    = 2'd0;
  localparam reg_idx_t REG_TUNE_LOW  = 2'd1;
  localparam reg_idx_t REG_TUNE_HIGH = 2'd2;
  localparam reg_idx_t REG_TUNE_SLOW = 2'd3;

  localparam logic [TUNE_W-1:0] TUNE_LOW_RST  = 32'd12178021;
  localparam logic [TUNE_W-1:0] TUNE_HIGH_RST = 32'd141733921;
  localparam logic [TUNE_W-1:0] TUNE_SLOW_RST = 32'd3623879;

  // Tone channels.
  typedef logic [1:0] ch_t;
  localparam ch_t CH_LOW  = 2'd0;
  localparam ch_t CH_HIGH = 2'd1;
  localparam ch_t CH_SLOW = 2'd2;

  localparam logic [WEIGHT_W-1:0] W_LOW  = 15'd16384;
  localparam logic [WEIGHT_W-1:0] W_HIGH = 15'd9830;
  localparam logic [WEIGHT_W-1:0] W_SLOW = 15'd6554;

  typedef struct packed {
    logic [AMP_W-1:0] amplitude;
    logic             last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mix_en;
    ch_t  wsel;
    logic neg;
    logic amp_en;
    logic abs_en;
    logic rnd_en;
  } mac_ctrl_t;

  function automatic logic [WEIGHT_W-1:0] weight(input ch_t ch);
    case (ch)
      CH_LOW:  return W_LOW;
      CH_HIGH: return W_HIGH;
      CH_SLOW: return W_SLOW;
      default: return '0;
    endcase
  endfunction

  // Quarter-wave sine at point q of 2^(sab-2) per quarter, unsigned Q0.15, by a Taylor
  // series through x^15/15!. Evaluated at elaboration only.
  function automatic logic [SINE_W-1:0] quarter_sine(input int sab, input longint unsigned q);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint          r;
    int              k;
    x    = (q * HALF_PI_Q30) >> (sab - 2);
    term = x;
    sum  = longint'(x);
    for (k = 1; k <= 7; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum <= 0) begin
      r = 0;
    end else begin
      r = (sum + 16384) >>> 15;
      if (r > 32767) begin
        r = 32767;
      end
    end
    return SINE_W'(r);
  endfunction

endpackage

// ===== rtl/ttdds_rom.sv =====
module ttdds_rom #(
  parameter int SINE_ADDR_BITS = ttdds_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [SINE_ADDR_BITS-2:0]           rd_idx,
  output logic [ttdds_pkg::SINE_W-1:0]        rd_data
);
  import ttdds_pkg::*;

  // One quarter wave plus its end point.
  localparam int DEPTH = (1 << (SINE_ADDR_BITS - 2)) + 1;

  typedef logic [SINE_W-1:0] tbl_t [DEPTH];

  function automatic tbl_t build_tbl();
    tbl_t t;
    for (int i = 0; i < DEPTH; i++) begin
      t[i] = quarter_sine(SINE_ADDR_BITS, longint'(i));
    end
    return t;
  endfunction

  localparam tbl_t SINE_TBL = build_tbl();

  logic [SINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= SINE_TBL[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ttdds_phase.sv =====
module ttdds_phase #(
  parameter int PHASE_BITS     = ttdds_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = ttdds_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 start,
  input  logic [ttdds_pkg::NCH-1:0][ttdds_pkg::TUNE_W-1:0]     tune,
  output logic                                                 busy,
  output logic [ttdds_pkg::NCH-1:0][SINE_ADDR_BITS-2:0]        idx,
  output logic [ttdds_pkg::NCH-1:0]                            neg
);
  import ttdds_pkg::*;

  localparam int NDIG   = (PHASE_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int PW     = NDIG * DIGIT_W;
  localparam int DCNT_W = $clog2(NDIG);
  localparam int IDX_W  = SINE_ADDR_BITS - 1;
  localparam logic [IDX_W-1:0] QTR = IDX_W'(1) << (SINE_ADDR_BITS - 2);

  // Bits above PHASE_BITS in the padded accumulators collect carries that
  // are never looked at, so the used bits still wrap modulo a full turn.
  logic [PW-1:0]        phase_r   [NCH];
  logic [PW-1:0]        tune_sh_r [NCH];
  logic [NCH-1:0]       carry_r;
  logic                 busy_r;
  logic [DCNT_W-1:0]    dcnt_r;
  logic [NCH-1:0][IDX_W-1:0] idx_r;
  logic [NCH-1:0]       neg_r;

  logic [PW-1:0]        tune_ext [NCH];
  logic [DIGIT_W:0]     dsum     [NCH];
  logic [NCH-1:0][IDX_W-1:0] idx_w;
  logic [NCH-1:0]       neg_w;

  always_comb begin
    logic [PW+TUNE_W-1:0]       tmp;
    logic [SINE_ADDR_BITS-1:0]  addr;
    logic [IDX_W-1:0]           off;
    for (int c = 0; c < NCH; c++) begin
      tmp         = {{PW{1'b0}}, tune[c]};
      tune_ext[c] = tmp[PW-1:0];
      dsum[c]     = {1'b0, phase_r[c][DIGIT_W-1:0]} + {1'b0, tune_sh_r[c][DIGIT_W-1:0]}
                    + (DIGIT_W+1)'(carry_r[c]);
      addr        = phase_r[c][PHASE_BITS-1 -: SINE_ADDR_BITS];
      off         = {1'b0, addr[SINE_ADDR_BITS-3:0]};
      // Odd quadrants run the quarter wave backwards; the upper half is negative.
      idx_w[c]    = addr[SINE_ADDR_BITS-2] ? (QTR - off) : off;
      neg_w[c]    = addr[SINE_ADDR_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        phase_r[c]   <= '0;
        tune_sh_r[c] <= '0;
      end
      carry_r <= '0;
      busy_r  <= 1'b0;
      dcnt_r  <= '0;
      idx_r   <= '0;
      neg_r   <= '0;
    end else if (start) begin
      // Sine addresses come from the phases as they stand before the step.
      for (int c = 0; c < NCH; c++) begin
        tune_sh_r[c] <= tune_ext[c];
      end
      idx_r   <= idx_w;
      neg_r   <= neg_w;
      carry_r <= '0;
      busy_r  <= 1'b1;
      dcnt_r  <= '0;
    end else if (busy_r) begin
      for (int c = 0; c < NCH; c++) begin
        phase_r[c]   <= {dsum[c][DIGIT_W-1:0], phase_r[c][PW-1:DIGIT_W]};
        tune_sh_r[c] <= tune_sh_r[c] >> DIGIT_W;
        carry_r[c]   <= dsum[c][DIGIT_W];
      end
      dcnt_r <= dcnt_r + 1'b1;
      if (dcnt_r == DCNT_W'(NDIG - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign idx  = idx_r;
  assign neg  = neg_r;

endmodule

// ===== rtl/ttdds_mac.sv =====
module ttdds_mac #(
  parameter int SAMPLE_BITS = ttdds_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  ttdds_pkg::mac_ctrl_t             ctrl,
  input  logic [ttdds_pkg::AMP_W-1:0]      amplitude,
  input  logic [ttdds_pkg::SINE_W-1:0]     sine_mag,
  output logic [SAMPLE_BITS-1:0]           result
);
  import ttdds_pkg::*;

  localparam int SH   = 46 - SAMPLE_BITS;
  localparam int PP_W = MIX_W + DIGIT_W + 1;
  localparam int RN_W = SAMPLE_BITS + 2;
  localparam logic [PROD_W-1:0] HALF   = {{(PROD_W-1){1'b0}}, 1'b1} << (SH - 1);
  localparam logic [RN_W-1:0]   HI_MAG = RN_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [RN_W-1:0]   LO_MAG = RN_W'(64'd1 << (SAMPLE_BITS - 1));

  logic signed [MIX_W-1:0]  mix_r;
  logic [AMP_W-1:0]         amp_sh_r;
  logic signed [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0]        mag_r;
  logic                     sign_r;
  logic [RN_W-1:0]          rnd_r;

  logic signed [SINE_W:0]   sine_s;
  logic signed [SINE_W:0]   w_s;
  logic signed [MIX_W-1:0]  wprod;
  logic [DIGIT_W-1:0]       digit;
  logic signed [PP_W-1:0]   pp;
  logic signed [PROD_W-1:0] acc_nxt;
  logic [PROD_W-1:0]        rsum;
  logic [RN_W-1:0]          rnd_neg;

  assign sine_s  = ctrl.neg ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
  assign w_s     = $signed({1'b0, weight(ctrl.wsel)});
  assign wprod   = MIX_W'(sine_s) * MIX_W'(w_s);

  // Gain is applied one four-bit amplitude digit per cycle, most significant first.
  assign digit   = amp_sh_r[AMP_W-1 -: DIGIT_W];
  assign pp      = PP_W'(mix_r) * PP_W'($signed({1'b0, digit}));
  assign acc_nxt = (acc_r <<< DIGIT_W) + PROD_W'(pp);

  assign rsum    = mag_r + HALF;
  assign rnd_neg = -rnd_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mix_r    <= '0;
      acc_r    <= '0;
      amp_sh_r <= amplitude;
    end else begin
      if (ctrl.mix_en) begin
        mix_r <= mix_r + wprod;
      end
      if (ctrl.amp_en) begin
        acc_r    <= acc_nxt;
        amp_sh_r <= amp_sh_r << DIGIT_W;
      end
    end
    if (ctrl.abs_en) begin
      mag_r  <= acc_r[PROD_W-1] ? PROD_W'(-acc_r) : PROD_W'(acc_r);
      sign_r <= acc_r[PROD_W-1];
    end
    if (ctrl.rnd_en) begin
      rnd_r <= rsum[SH +: RN_W];
    end
  end

  // Rounding was done on the magnitude, so ties go away from zero.
  always_comb begin
    if (!sign_r) begin
      result = (rnd_r > HI_MAG) ? HI_MAG[SAMPLE_BITS-1:0] : rnd_r[SAMPLE_BITS-1:0];
    end else begin
      result = (rnd_r > LO_MAG) ? LO_MAG[SAMPLE_BITS-1:0] : rnd_neg[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== rtl/three_tone_dds_mixer.sv =====
// Three-tone sine generator: every accepted request is one sample tick whose
// amplitude scales the 0.5/0.3/0.2 mix of three DDS tones, each stepped by its
// own tuning word, giving one saturated signed sample that carries the request's
// last flag. With enable clear a request is taken without starting the sequencer,
// gives no sample and leaves the phases alone. An enabled request goes through
// the look, amplitude, absolute-value, rounding and output states to the output
// register, and no new request is taken until the sequencer is idle again and
// the phase adders are done; the work is done by the three reads of the single
// quarter-wave sine table, the four-bit digit-serial amplitude multiply, and
// the four-bit digit-serial phase adders. A finished sample waits in the output
// register while the next request is already taken.
module three_tone_dds_mixer #(
  parameter int PHASE_BITS     = ttdds_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = ttdds_pkg::SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS    = ttdds_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ttdds_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ttdds_pkg::out_item_t                out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ttdds_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import ttdds_pkg::*;

  localparam int IDX_W = SINE_ADDR_BITS - 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOOK = 6'b000010,
    S_AMP  = 6'b000100,
    S_ABS  = 6'b001000,
    S_RND  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              enable_r;
  logic [TUNE_W-1:0] tune_low_r, tune_high_r, tune_slow_r;
  logic              last_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              accept;
  logic              start;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  logic              phase_busy;
  logic [NCH-1:0][TUNE_W-1:0] tune_words;
  logic [NCH-1:0][IDX_W-1:0]  sine_idx;
  logic [NCH-1:0]    sine_neg;
  logic              rom_en;
  logic [IDX_W-1:0]  rom_idx;
  logic [SINE_W-1:0] rom_data;
  mac_ctrl_t         mac_ctrl;
  ch_t               acc_ch;
  logic [SAMPLE_BITS-1:0]          mac_result;
  logic [SAMPLE_W+SAMPLE_BITS-1:0] sample_ext;
  logic              out_free;

  assign accept   = in_valid && !in_stall;
  assign start    = accept && enable_r;
  assign in_stall = (state_r != S_IDLE) || phase_busy;
  assign out_free = !out_valid_r || !out_stall;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      tune_low_r  <= TUNE_LOW_RST;
      tune_high_r <= TUNE_HIGH_RST;
      tune_slow_r <= TUNE_SLOW_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENABLE:    enable_r    <= pwdata[0];
        REG_TUNE_LOW:  tune_low_r  <= pwdata;
        REG_TUNE_HIGH: tune_high_r <= pwdata;
        REG_TUNE_SLOW: tune_slow_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENABLE:    prdata = {31'b0, enable_r};
      REG_TUNE_LOW:  prdata = tune_low_r;
      REG_TUNE_HIGH: prdata = tune_high_r;
      REG_TUNE_SLOW: prdata = tune_slow_r;
      default:       prdata = '0;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(LOOK_LEN - 1)) begin
          state_nxt = S_AMP;
          cnt_nxt   = '0;
        end
      end
      S_AMP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(AMP_DIGITS - 1)) begin
          state_nxt = S_ABS;
          cnt_nxt   = '0;
        end
      end
      S_ABS: state_nxt = S_RND;
      S_RND: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      last_r <= in_data.last_in;
    end
  end

  // The table is read for channels 0..2 at look counter values 0..2; each value is
  // weighted in the following look cycle, when the registered read data arrives.
  assign acc_ch = ch_t'(cnt_r - 1'b1);
  assign rom_en = (state_r == S_LOOK) && (cnt_r != CNT_W'(LOOK_LEN - 1));

  always_comb begin
    case (ch_t'(cnt_r))
      CH_LOW:  rom_idx = sine_idx[CH_LOW];
      CH_HIGH: rom_idx = sine_idx[CH_HIGH];
      CH_SLOW: rom_idx = sine_idx[CH_SLOW];
      default: rom_idx = sine_idx[CH_LOW];
    endcase
  end

  always_comb begin
    mac_ctrl        = '0;
    mac_ctrl.load   = start;
    mac_ctrl.mix_en = (state_r == S_LOOK) && (cnt_r != '0);
    mac_ctrl.wsel   = acc_ch;
    mac_ctrl.amp_en = (state_r == S_AMP);
    mac_ctrl.abs_en = (state_r == S_ABS);
    mac_ctrl.rnd_en = (state_r == S_RND);
    case (acc_ch)
      CH_LOW:  mac_ctrl.neg = sine_neg[CH_LOW];
      CH_HIGH: mac_ctrl.neg = sine_neg[CH_HIGH];
      CH_SLOW: mac_ctrl.neg = sine_neg[CH_SLOW];
      default: mac_ctrl.neg = 1'b0;
    endcase
  end

  assign tune_words = {tune_slow_r, tune_high_r, tune_low_r};

  ttdds_phase #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_phase (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .tune  (tune_words),
    .busy  (phase_busy),
    .idx   (sine_idx),
    .neg   (sine_neg)
  );

  ttdds_rom #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (rom_en),
    .rd_idx  (rom_idx),
    .rd_data (rom_data)
  );

  ttdds_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk       (clk),
    .ctrl      (mac_ctrl),
    .amplitude (in_data.amplitude),
    .sine_mag  (rom_data),
    .result    (mac_result)
  );

  // The sample field carries the low SAMPLE_BITS bits of the result, zero above.
  assign sample_ext = {{SAMPLE_W{1'b0}}, mac_result};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_data_r.sample <= sample_ext[SAMPLE_W-1:0];
      out_data_r.last   <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/ttdds_checker.sv =====
module ttdds_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input ttdds_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input ttdds_pkg::out_item_t out_data
);
  import ttdds_pkg::*;

  // Edges from acceptance of a request to the first edge that sees its sample
  // in a free output register.
  localparam int LAT = 12;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_out_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, LAT))
    else $error("result appeared without a request at the fixed latency");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_data.last == $past(in_data.last_in, LAT))
    else $error("last flag does not match its request");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind three_tone_dds_mixer ttdds_checker u_ttdds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
